// File: sv/sme_pkg.sv
// Package with the shared types and constants of the specificity engine.
`timescale 1ns / 1ps
package sme_pkg;
  localparam int MaxClasses = 16;
  localparam int CountWidth = 32;
  localparam int ClassW = 4;
  localparam int RatioW = 17;
  localparam int SumW = CountWidth + ClassW + 1;

  typedef struct packed {
    logic [ClassW-1:0] actual_class;
    logic [ClassW-1:0] predicted_class;
    logic              end_of_set;
  } in_word_t;

  typedef struct packed {
    logic [ClassW-1:0] class_index;
    logic [RatioW-1:0] specificity_value;
    logic              last_result;
  } out_word_t;

  typedef enum logic {
    CFG_CLASS_COUNT    = 1'b0,
    CFG_AGGREGATE_MODE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic            start;
    logic [SumW-1:0] num;
    logic [SumW-1:0] den;
  } div_req_t;
endpackage

// File: sv/sme_divider.sv
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module sme_divider
  import sme_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  sme_pkg::div_req_t req,
  output logic              done,
  output logic [sme_pkg::RatioW-1:0] quot
);
  logic [SumW:0]         rem_r;
  logic [SumW-1:0]       den_r;
  logic [RatioW-1:0]     q_r;
  logic [4:0]            cnt_r;
  logic                  busy_r;
  logic                  ge;
  logic [SumW:0]         sub;

  assign ge = rem_r >= {1'b0, den_r};
  assign sub = ge ? rem_r - {1'b0, den_r} : rem_r;
  assign quot = q_r;
  assign done = busy_r && (cnt_r == 5'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'(RatioW);
      rem_r  <= {1'b0, req.num};
      den_r  <= req.den;
      q_r    <= '0;
    end else if (busy_r) begin
      if (cnt_r == 5'd0) begin
        busy_r <= 1'b0;
        if (den_r == '0) q_r <= '0;
      end else begin
        cnt_r <= cnt_r - 5'd1;
        q_r   <= {q_r[RatioW-2:0], ge};
        rem_r <= {sub[SumW-1:0], 1'b0};
      end
    end
  end
endmodule

// File: sv/specificity_metric_engine_unit.sv
// Top level of the specificity engine: counters, sweep sequencer and output register.
// While idle (input stall low), a sample without end_of_set is counted, one sample per cycle.
// On end_of_set, each class passes through terms, divider start, the divider and output load,
// in that order; in aggregate mode the terms of all k classes are summed before one division.
// Input stall is high during the sweep. Synchronous active-low reset clears all
// counters and sets class_count to 2 and aggregate_mode to 0.
`timescale 1ns / 1ps
module specificity_metric_engine_unit
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sme_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sme_pkg::out_word_t   out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [4:0]           cfg_data
);
  import sme_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_TERM, S_ACC, S_DIV, S_WAIT, S_OUT} state_t;

  localparam logic [CountWidth-1:0] CMax = '1;

  state_t state_r;
  logic [4:0] class_count_r;
  logic aggregate_r;
  logic [CountWidth-1:0] tp_r [MaxClasses];
  logic [CountWidth-1:0] ac_r [MaxClasses];
  logic [CountWidth-1:0] pc_r [MaxClasses];
  logic [CountWidth-1:0] tot_r;
  logic [ClassW-1:0] idx_r;
  logic [SumW-1:0] tn_r, fp_r;
  logic [CountWidth-1:0] tn_c, fp_c;
  logic [CountWidth+1:0] t_wide;
  logic [4:0] k;
  logic [ClassW-1:0] k_last;
  logic hit, in_acc, last_idx;
  div_req_t req;
  logic div_done;
  logic [RatioW-1:0] quot;
  logic out_valid_r;
  out_word_t out_r;

  sme_divider u_div (.clk(clk), .rst_n(rst_n), .req(req), .done(div_done), .quot(quot));

  always_comb begin
    k = class_count_r;
    if (k == 5'd0) k = 5'd1;
    if (k > 5'(MaxClasses)) k = 5'(MaxClasses);
  end
  assign k_last = ClassW'(k - 5'd1);
  assign last_idx = idx_r == k_last;

  assign in_stall = state_r != S_IDLE;
  assign in_acc = in_valid && !in_stall;
  assign hit = ({1'b0, in_data.actual_class} < k) && ({1'b0, in_data.predicted_class} < k);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_comb begin
    t_wide = {2'b0, tot_r} - {2'b0, ac_r[idx_r]} - {2'b0, pc_r[idx_r]}
             + {2'b0, tp_r[idx_r]};
    tn_c = t_wide[CountWidth+1] ? '0 : t_wide[CountWidth-1:0];
    fp_c = (pc_r[idx_r] > tp_r[idx_r]) ? pc_r[idx_r] - tp_r[idx_r] : '0;
  end

  always_comb begin
    req.start = state_r == S_DIV;
    req.num = tn_r;
    req.den = tn_r + fp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      class_count_r <= 5'd2;
      aggregate_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r <= '0;
      tot_r <= '0;
      for (int i = 0; i < MaxClasses; i++) begin
        tp_r[i] <= '0;
        ac_r[i] <= '0;
        pc_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_CLASS_COUNT:    class_count_r <= cfg_data;
          CFG_AGGREGATE_MODE: aggregate_r <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (hit) begin
              if (ac_r[in_data.actual_class] != CMax)
                ac_r[in_data.actual_class] <= ac_r[in_data.actual_class] + 1'b1;
              if (pc_r[in_data.predicted_class] != CMax)
                pc_r[in_data.predicted_class] <= pc_r[in_data.predicted_class] + 1'b1;
              if (in_data.actual_class == in_data.predicted_class &&
                  tp_r[in_data.actual_class] != CMax)
                tp_r[in_data.actual_class] <= tp_r[in_data.actual_class] + 1'b1;
              if (tot_r != CMax) tot_r <= tot_r + 1'b1;
            end
            if (in_data.end_of_set) begin
              idx_r <= '0;
              tn_r <= '0;
              fp_r <= '0;
              state_r <= aggregate_r ? S_ACC : S_TERM;
            end
          end
        end
        S_TERM: begin
          tn_r <= SumW'(tn_c);
          fp_r <= SumW'(fp_c);
          state_r <= S_DIV;
        end
        S_ACC: begin
          tn_r <= tn_r + SumW'(tn_c);
          fp_r <= fp_r + SumW'(fp_c);
          if (last_idx) state_r <= S_DIV;
          else idx_r <= idx_r + 1'b1;
        end
        S_DIV: state_r <= S_WAIT;
        S_WAIT: begin
          if (div_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_r.class_index <= aggregate_r ? '0 : idx_r;
            out_r.specificity_value <= quot;
            out_r.last_result <= aggregate_r || last_idx;
            if (aggregate_r || last_idx) begin
              state_r <= S_IDLE;
              idx_r <= '0;
              tot_r <= '0;
              for (int i = 0; i < MaxClasses; i++) begin
                tp_r[i] <= '0;
                ac_r[i] <= '0;
                pc_r[i] <= '0;
              end
            end else begin
              idx_r <= idx_r + 1'b1;
              state_r <= S_TERM;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
